@@ src/ppf_pkg.sv @@
package ppf_pkg;

  // Queue geometry
  localparam int DEPTH       = 16;
  localparam int DATA_WIDTH  = 32;
  localparam int LEVEL_WIDTH = 8;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);

  // Command codes
  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_POP   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Push status codes
  localparam logic [2:0] ST_NONE       = 3'd0;
  localparam logic [2:0] ST_APPENDED   = 3'd1;
  localparam logic [2:0] ST_REPLACED   = 3'd2;
  localparam logic [2:0] ST_DROP_LOWER = 3'd3;
  localparam logic [2:0] ST_DROP_FULL  = 3'd4;

  // Storage access issued by the bookkeeping logic
  typedef struct packed {
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
  } ram_req_t;

  // Result fields known at the time of the request
  typedef struct packed {
    logic                   pop_valid;
    logic [2:0]             push_status;
    logic                   queue_empty;
    logic [LEVEL_WIDTH-1:0] current_level;
  } res_t;

  // Advance a ring index with wrap
  function automatic logic [ADDR_W-1:0] next_slot(input logic [ADDR_W-1:0] idx);
    next_slot = (idx == ADDR_W'(DEPTH - 1)) ? '0 : idx + ADDR_W'(1);
  endfunction

endpackage

@@ src/ppf_ram.sv @@
module ppf_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/ppf_ctrl.sv @@
module ppf_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic [1:0]                     command,
  input  logic [ppf_pkg::DATA_WIDTH-1:0] item_value,
  input  logic [ppf_pkg::LEVEL_WIDTH-1:0] item_priority,
  output ppf_pkg::ram_req_t              ram_req,
  output ppf_pkg::res_t                  res
);

  logic [ppf_pkg::ADDR_W-1:0]      read_index, read_index_next;
  logic [ppf_pkg::ADDR_W-1:0]      write_index, write_index_next;
  logic [ppf_pkg::CNT_W-1:0]       item_count, item_count_next;
  logic [ppf_pkg::LEVEL_WIDTH-1:0] held_level, held_level_next;

  // Decide the queue update and storage access for one request
  always_comb begin
    read_index_next  = read_index;
    write_index_next = write_index;
    item_count_next  = item_count;
    held_level_next  = held_level;
    ram_req          = '0;
    ram_req.wr_data  = item_value;
    res.pop_valid    = 1'b0;
    res.push_status  = ppf_pkg::ST_NONE;

    if (accept) begin
      case (command)
        ppf_pkg::CMD_PUSH: begin
          if (item_count == '0 || item_priority > held_level) begin
            // start a fresh queue holding just this item
            ram_req.wr_en    = 1'b1;
            ram_req.wr_addr  = '0;
            read_index_next  = '0;
            write_index_next = ppf_pkg::next_slot('0);
            item_count_next  = ppf_pkg::CNT_W'(1);
            held_level_next  = item_priority;
            res.push_status  = (item_count == '0) ? ppf_pkg::ST_APPENDED
                                                  : ppf_pkg::ST_REPLACED;
          end else if (item_priority == held_level) begin
            if (item_count == ppf_pkg::CNT_W'(ppf_pkg::DEPTH)) begin
              res.push_status = ppf_pkg::ST_DROP_FULL;
            end else begin
              ram_req.wr_en    = 1'b1;
              ram_req.wr_addr  = write_index;
              write_index_next = ppf_pkg::next_slot(write_index);
              item_count_next  = item_count + ppf_pkg::CNT_W'(1);
              res.push_status  = ppf_pkg::ST_APPENDED;
            end
          end else begin
            res.push_status = ppf_pkg::ST_DROP_LOWER;
          end
        end
        ppf_pkg::CMD_POP: begin
          if (item_count != '0) begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = read_index;
            res.pop_valid   = 1'b1;
            if (item_count == ppf_pkg::CNT_W'(1)) begin
              read_index_next  = '0;
              write_index_next = '0;
              item_count_next  = '0;
              held_level_next  = '0;
            end else begin
              read_index_next = ppf_pkg::next_slot(read_index);
              item_count_next = item_count - ppf_pkg::CNT_W'(1);
            end
          end
        end
        ppf_pkg::CMD_CLEAR: begin
          read_index_next  = '0;
          write_index_next = '0;
          item_count_next  = '0;
          held_level_next  = '0;
        end
        default: begin
        end
      endcase
    end

    res.queue_empty   = (item_count_next == '0);
    res.current_level = (item_count_next == '0) ? '0 : held_level_next;
  end

  // Hold queue bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      read_index  <= '0;
      write_index <= '0;
      item_count  <= '0;
      held_level  <= '0;
    end else begin
      read_index  <= read_index_next;
      write_index <= write_index_next;
      item_count  <= item_count_next;
      held_level  <= held_level_next;
    end
  end

endmodule

@@ src/priority_preempting_fifo_top.sv @@
// Channel  Handshake              Payload
// in       in_valid / in_ready    command, item_value, item_priority
// out      out_valid / out_ready  pop_data, pop_valid, push_status, queue_empty, current_level
//
// Push, clear and no-op results are registered directly; a pop that returns an
// item first passes through the S_READ state, as the item store's read port is registered.
// The next request is taken while a result waits only if out_ready drains it.
// Synchronous reset empties the queue; store contents stay undefined.
// A stall on out holds the result register and blocks new requests.
// Reads and writes of the store never overlap: requests are taken one at a time.
module priority_preempting_fifo_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      command,
  input  logic [ppf_pkg::DATA_WIDTH-1:0]  item_value,
  input  logic [ppf_pkg::LEVEL_WIDTH-1:0] item_priority,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ppf_pkg::DATA_WIDTH-1:0]  pop_data,
  output logic                            pop_valid,
  output logic [2:0]                      push_status,
  output logic                            queue_empty,
  output logic [ppf_pkg::LEVEL_WIDTH-1:0] current_level
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic                          state;
  logic                          accept;
  ppf_pkg::ram_req_t             ram_req;
  ppf_pkg::res_t                 res;
  logic [ppf_pkg::DATA_WIDTH-1:0] rd_data;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  ppf_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .command       (command),
    .item_value    (item_value),
    .item_priority (item_priority),
    .ram_req       (ram_req),
    .res           (res)
  );

  ppf_ram #(
    .DEPTH (ppf_pkg::DEPTH),
    .WIDTH (ppf_pkg::DATA_WIDTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_req.wr_en),
    .wr_addr (ram_req.wr_addr),
    .wr_data (ram_req.wr_data),
    .rd_en   (ram_req.rd_en),
    .rd_addr (ram_req.rd_addr),
    .rd_data (rd_data)
  );

  // Sequence requests and show results
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (res.pop_valid) begin
              state     <= S_READ;
              out_valid <= 1'b0;
            end else begin
              out_valid <= 1'b1;
            end
          end else if (out_ready) begin
            out_valid <= 1'b0;
          end
        end
        S_READ: begin
          state     <= S_IDLE;
          out_valid <= 1'b1;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Capture result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      pop_valid     <= res.pop_valid;
      push_status   <= res.push_status;
      queue_empty   <= res.queue_empty;
      current_level <= res.current_level;
      pop_data      <= '0;
    end else if (state == S_READ) begin
      pop_data <= rd_data;
    end
  end

endmodule

@@ src/ppf_checker.sv @@
module ppf_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [ppf_pkg::DATA_WIDTH-1:0]  pop_data,
  input logic                            pop_valid,
  input logic [2:0]                      push_status,
  input logic                            queue_empty,
  input logic [ppf_pkg::LEVEL_WIDTH-1:0] current_level
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Empty queue reports level zero
  a_empty_level: assert property (@(posedge clk) disable iff (rst)
    out_valid && queue_empty |-> current_level == '0)
    else $error("nonzero level on empty queue");

  // Pop results carry no push status
  a_pop_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && pop_valid |-> push_status == ppf_pkg::ST_NONE)
    else $error("push status on a pop");

  // No data without a popped item
  a_pop_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pop_valid |-> pop_data == '0)
    else $error("pop data without a popped item");

  // A stored push leaves the queue occupied
  a_push_fill: assert property (@(posedge clk) disable iff (rst)
    out_valid && (push_status == ppf_pkg::ST_APPENDED ||
                  push_status == ppf_pkg::ST_REPLACED) |-> !queue_empty)
    else $error("queue empty after a stored push");

endmodule

bind priority_preempting_fifo_top ppf_checker u_ppf_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .pop_data      (pop_data),
  .pop_valid     (pop_valid),
  .push_status   (push_status),
  .queue_empty   (queue_empty),
  .current_level (current_level)
);
